// ----- rtl/luss_pkg.sv -----
// Shared types and constants of the LU linear system solver.
package luss_pkg;

    localparam int Q_W       = 32;
    localparam int MAX_ORDER = 8;

    localparam logic [1:0] CMD_MAT   = 2'd0;
    localparam logic [1:0] CMD_RHS   = 2'd1;
    localparam logic [1:0] CMD_SOLVE = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_PIVOT = 2'd1;
    localparam logic [1:0] STS_SAT   = 2'd2;

    typedef struct packed {
        logic clr;
        logic mul;
        logic acc;
        logic sub;
    } t_mac_ctl;

endpackage

// ----- rtl/luss_div.sv -----
// Bit-serial signed fixed-point divider, truncating quotient with saturation.
module luss_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [luss_pkg::Q_W-1:0]  i_num,
    input  logic signed [luss_pkg::Q_W-1:0]  i_den,
    output logic                             o_done,
    output logic signed [luss_pkg::Q_W-1:0]  o_quot,
    output logic                             o_sat
);
    import luss_pkg::*;

    localparam int NW = Q_W + FRAC_BITS;
    localparam int CNW = $clog2(NW + 1);

    typedef enum logic [1:0] { DS_IDLE, DS_RUN, DS_FIN } t_dstate;

    t_dstate            r_state;
    logic [NW-1:0]      r_dvd;
    logic [NW-1:0]      r_q;
    logic [Q_W:0]       r_rem;
    logic [Q_W-1:0]     r_dmag;
    logic               r_neg;
    logic [CNW-1:0]     r_cnt;
    logic               r_done;
    logic [Q_W-1:0]     r_quot;
    logic               r_sat;

    logic [Q_W:0]       rem_sh;
    logic               q_bit;
    logic [Q_W-1:0]     num_mag;
    logic [Q_W-1:0]     den_mag;

    assign num_mag = i_num[Q_W-1] ? Q_W'(-i_num) : Q_W'(i_num);
    assign den_mag = i_den[Q_W-1] ? Q_W'(-i_den) : Q_W'(i_den);
    assign rem_sh  = {r_rem[Q_W-1:0], r_dvd[NW-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_dmag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == DS_FIN);
            case (r_state)
                DS_IDLE: begin
                    if (i_start) begin
                        r_dvd   <= {num_mag, {FRAC_BITS{1'b0}}};
                        r_dmag  <= den_mag;
                        r_neg   <= i_num[Q_W-1] ^ i_den[Q_W-1];
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_cnt   <= CNW'(NW);
                        r_state <= DS_RUN;
                    end
                end
                DS_RUN: begin
                    r_rem <= q_bit ? (rem_sh - {1'b0, r_dmag}) : rem_sh;
                    r_dvd <= r_dvd << 1;
                    r_q   <= {r_q[NW-2:0], q_bit};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNW'(1)) begin
                        r_state <= DS_FIN;
                    end
                end
                DS_FIN: begin
                    if (!r_neg && r_q > NW'(64'h7FFF_FFFF)) begin
                        r_quot <= 32'h7FFF_FFFF;
                        r_sat  <= 1'b1;
                    end else if (r_neg && r_q > NW'(64'h8000_0000)) begin
                        r_quot <= 32'h8000_0000;
                        r_sat  <= 1'b1;
                    end else begin
                        r_quot <= r_neg ? Q_W'(-r_q) : Q_W'(r_q);
                        r_sat  <= 1'b0;
                    end
                    r_state <= DS_IDLE;
                end
                default: r_state <= DS_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_sat  = r_sat;

endmodule

// ----- rtl/luss_mac.sv -----
// Shared multiply-accumulate unit with saturating final subtract.
module luss_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  luss_pkg::t_mac_ctl               i_ctl,
    input  logic signed [luss_pkg::Q_W-1:0]  i_a,
    input  logic signed [luss_pkg::Q_W-1:0]  i_b,
    input  logic signed [luss_pkg::Q_W-1:0]  i_tgt,
    output logic signed [luss_pkg::Q_W-1:0]  o_res,
    output logic                             o_sat
);
    import luss_pkg::*;

    localparam logic signed [2*Q_W:0] D_MAX = 65'sd2147483647;
    localparam logic signed [2*Q_W:0] D_MIN = -65'sd2147483648;

    logic signed [2*Q_W-1:0] r_prod;
    logic signed [2*Q_W-1:0] r_acc;
    logic signed [Q_W-1:0]   r_res;
    logic                    r_sat;
    logic signed [2*Q_W:0]   diff;

    assign diff = (2*Q_W+1)'(i_tgt) - (2*Q_W+1)'(r_acc);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= (2*Q_W)'(i_a) * (2*Q_W)'(i_b);
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= r_acc + (r_prod >>> FRAC_BITS);
        end
        if (i_ctl.sub) begin
            if (diff > D_MAX) begin
                r_res <= 32'sh7FFF_FFFF;
                r_sat <= 1'b1;
            end else if (diff < D_MIN) begin
                r_res <= 32'sh8000_0000;
                r_sat <= 1'b1;
            end else begin
                r_res <= Q_W'(diff);
                r_sat <= 1'b0;
            end
        end
    end

    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

// ----- rtl/lu_linear_system_solver.sv -----
// Loads are taken one per cycle while idle; a solve runs LU factorization and both substitutions, then streams x.
// Each element runs its multiply-accumulates on the shared multiplier and, for L entries and
// backward substitution, a division in the bit-serial divider; results then stream from
// index n-1 down to 0, one per cycle while the output is ready.
// Throughput: loads take one transfer per cycle; no transfer is taken while a solve runs.
// Reset is synchronous active low; matrix and vector stores are undefined until written.
module lu_linear_system_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // row_index, col_index, entry_value, zero fill
    input  logic [1:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // unknown_index, solution_value, zero fill
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast
);
    import luss_pkg::*;

    localparam int IW    = $clog2(MAX_ORDER);
    localparam int CW    = $clog2(MAX_ORDER + 1);
    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ELEM, ST_LATCH, ST_MAC_RD, ST_MAC_MUL, ST_MAC_ACC,
        ST_SUB, ST_CHK, ST_DIV_WAIT, ST_WRITE, ST_OUT
    } t_state;

    typedef enum logic [1:0] { PH_FU, PH_FL, PH_FWD, PH_BWD } t_phase;

    t_state             r_state;
    t_phase             r_phase;
    logic [3:0]         r_cfg;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_j;
    logic [CW-1:0]      r_k;
    logic               r_pflag;
    logic               r_sflag;
    logic signed [31:0] r_tgt;
    logic signed [31:0] r_piv;
    logic signed [31:0] r_solq;
    logic signed [31:0] r_res;
    logic               r_ovalid;
    logic [2:0]         r_oidx;
    logic signed [31:0] r_oval;
    logic [1:0]         r_osts;
    logic               r_olast;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_a;
    logic signed [31:0] r_rd_b;
    logic signed [31:0] r_rhs [MAX_ORDER];
    logic signed [31:0] r_sol [MAX_ORDER];

    logic [2:0]         in_row;
    logic [2:0]         in_col;
    logic signed [31:0] in_val;
    logic               in_xfer;
    logic               row_ok;
    logic               col_ok;
    logic [AW-1:0]      addr_a;
    logic [AW-1:0]      addr_b;
    logic [AW-1:0]      mem_wa;
    logic               mem_we;
    logic signed [31:0] mem_wd;
    logic [IW-1:0]      sol_ra;
    logic signed [31:0] sol_rd;
    logic [CW-1:0]      k_start;
    logic [CW-1:0]      k_end;
    logic               is_fact;
    logic               need_div;
    t_mac_ctl           mac_ctl;
    logic signed [31:0] mac_b;
    logic signed [31:0] mac_res;
    logic               mac_sat;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quot;
    logic               div_sat;

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(r[IW-1:0]) * AW'(MAX_ORDER) + AW'(c[IW-1:0]);
    endfunction

    assign in_row  = s_axis_tdata[2:0];
    assign in_col  = s_axis_tdata[5:3];
    assign in_val  = s_axis_tdata[37:6];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign row_ok  = (int'(in_row) < MAX_ORDER);
    assign col_ok  = (int'(in_col) < MAX_ORDER);

    assign is_fact  = (r_phase == PH_FU) || (r_phase == PH_FL);
    assign need_div = (r_phase == PH_FL) || (r_phase == PH_BWD);
    assign k_start  = (r_phase == PH_BWD) ? r_i + 1'b1 : '0;
    assign k_end    = (r_phase == PH_BWD) ? r_n : r_i;

    always_comb begin
        addr_a = '0;
        addr_b = f_addr(r_i, r_i);
        if (r_state == ST_MAC_RD) begin
            case (r_phase)
                PH_FU: begin
                    addr_a = f_addr(r_i, r_k);
                    addr_b = f_addr(r_k, r_j);
                end
                PH_FL: begin
                    addr_a = f_addr(r_j, r_k);
                    addr_b = f_addr(r_k, r_i);
                end
                default: addr_a = f_addr(r_i, r_k);
            endcase
        end else begin
            addr_a = (r_phase == PH_FL) ? f_addr(r_j, r_i) : f_addr(r_i, r_j);
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = (r_phase == PH_FL) ? f_addr(r_j, r_i) : f_addr(r_i, r_j);
        mem_wd = r_res;
        if (r_state == ST_IDLE) begin
            mem_we = in_xfer && (s_axis_tuser == CMD_MAT) && row_ok && col_ok;
            mem_wa = AW'(in_row) * AW'(MAX_ORDER) + AW'(in_col);
            mem_wd = in_val;
        end else if (r_state == ST_WRITE) begin
            mem_we = is_fact;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    assign sol_ra = (r_state == ST_MAC_RD) ? r_k[IW-1:0] : r_i[IW-1:0];
    assign sol_rd = r_sol[sol_ra];

    always_ff @(posedge i_clk) begin
        if (in_xfer && (s_axis_tuser == CMD_RHS) && row_ok) begin
            r_rhs[IW'(in_row)] <= in_val;
        end
        if (r_state == ST_WRITE && !is_fact) begin
            r_sol[r_i[IW-1:0]] <= r_res;
        end
    end

    always_comb begin
        mac_ctl     = '0;
        mac_ctl.clr = (r_state == ST_LATCH);
        mac_ctl.mul = (r_state == ST_MAC_MUL);
        mac_ctl.acc = (r_state == ST_MAC_ACC);
        mac_ctl.sub = (r_state == ST_SUB);
    end

    assign mac_b     = is_fact ? r_rd_b : r_solq;
    assign div_start = (r_state == ST_CHK) && need_div && (r_piv != '0);

    luss_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (r_rd_a),
        .i_b   (mac_b),
        .i_tgt (r_tgt),
        .o_res (mac_res),
        .o_sat (mac_sat)
    );

    luss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mac_res),
        .i_den   (r_piv),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_sat   (div_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_FU;
            r_cfg    <= 4'd4;
            r_n      <= CW'(1);
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_pflag  <= 1'b0;
            r_sflag  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready && r_state != ST_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer && s_axis_tuser == CMD_SOLVE) begin
                        if (r_cfg == 4'd0) begin
                            r_n <= CW'(1);
                        end else if (int'(r_cfg) > MAX_ORDER) begin
                            r_n <= CW'(MAX_ORDER);
                        end else begin
                            r_n <= CW'(r_cfg);
                        end
                        r_pflag <= 1'b0;
                        r_sflag <= 1'b0;
                        r_phase <= PH_FU;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= ST_ELEM;
                    end
                end
                ST_ELEM: r_state <= ST_LATCH;
                ST_LATCH: begin
                    case (r_phase)
                        PH_FWD:  r_tgt <= r_rhs[r_i[IW-1:0]];
                        PH_BWD:  r_tgt <= sol_rd;
                        default: r_tgt <= r_rd_a;
                    endcase
                    r_piv   <= r_rd_b;
                    r_k     <= k_start;
                    r_state <= (k_start < k_end) ? ST_MAC_RD : ST_SUB;
                end
                ST_MAC_RD: begin
                    r_solq  <= sol_rd;
                    r_state <= ST_MAC_MUL;
                end
                ST_MAC_MUL: r_state <= ST_MAC_ACC;
                ST_MAC_ACC: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k + 1'b1 < k_end) ? ST_MAC_RD : ST_SUB;
                end
                ST_SUB: r_state <= ST_CHK;
                ST_CHK: begin
                    r_sflag <= r_sflag | mac_sat;
                    if (!need_div) begin
                        r_res   <= mac_res;
                        r_state <= ST_WRITE;
                    end else if (r_piv == '0) begin
                        r_res   <= '0;
                        r_pflag <= 1'b1;
                        r_state <= ST_WRITE;
                    end else begin
                        r_state <= ST_DIV_WAIT;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        r_res   <= div_quot;
                        r_sflag <= r_sflag | div_sat;
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (r_phase != PH_BWD) begin
                        r_state <= ST_ELEM;
                    end
                    case (r_phase)
                        PH_FU: begin
                            if (r_j + 1'b1 < r_n) begin
                                r_j <= r_j + 1'b1;
                            end else if (r_i + 1'b1 < r_n) begin
                                r_phase <= PH_FL;
                                r_j     <= r_i + 1'b1;
                            end else begin
                                r_phase <= PH_FWD;
                                r_i     <= '0;
                            end
                        end
                        PH_FL: begin
                            if (r_j + 1'b1 < r_n) begin
                                r_j <= r_j + 1'b1;
                            end else begin
                                r_phase <= PH_FU;
                                r_i     <= r_i + 1'b1;
                                r_j     <= r_i + 1'b1;
                            end
                        end
                        PH_FWD: begin
                            if (r_i + 1'b1 < r_n) begin
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_phase <= PH_BWD;
                                r_i     <= r_n - 1'b1;
                            end
                        end
                        PH_BWD: begin
                            if (r_i != '0) begin
                                r_i     <= r_i - 1'b1;
                                r_state <= ST_ELEM;
                            end else begin
                                r_i     <= r_n - 1'b1;
                                r_state <= ST_OUT;
                            end
                        end
                        default: r_phase <= PH_FU;
                    endcase
                end
                ST_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= 3'(r_i);
                        r_oval   <= sol_rd;
                        r_osts   <= r_pflag ? STS_PIVOT : (r_sflag ? STS_SAT : STS_OK);
                        r_olast  <= (r_i == '0);
                        if (r_i == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_i <= r_i - 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'b0, r_oval, r_oidx};
    assign m_axis_tuser  = r_osts;
    assign m_axis_tlast  = r_olast;

    a_last_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[2:0] == 3'd0)
        else $error("last transfer carries a nonzero index");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("undefined status code");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_i < r_n && r_n != '0)
        else $error("row counter beyond order");

    a_mac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MAC_RD |-> r_k < k_end)
        else $error("inner counter beyond range");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> r_state == ST_DIV_WAIT)
        else $error("divider started outside division step");

endmodule

// ----- tb/testbench.sv -----
// Testbench for the LU linear system solver: directed table, then random systems.
`timescale 1ns / 100ps

module testbench;
    import luss_pkg::*;

    localparam int NMAX = 8;
    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] val;
        bit          known;
        logic [31:0] xval;
        logic [1:0]  xsts;
    } stim_row_t;

    typedef struct {
        logic [2:0]  idx;
        logic [31:0] val;
        logic [1:0]  sts;
        logic        last;
    } x_item_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // row_index, col_index, entry_value, zero fill
    logic [1:0]  s_axis_tuser = '0;   // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // unknown_index, solution_value, zero fill
    logic [1:0]  m_axis_tuser;        // status
    logic        m_axis_tlast;

    lu_linear_system_solver dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    logic signed [31:0] lu_cell [NMAX*NMAX];
    logic signed [31:0] rhs_vec [NMAX];
    logic signed [31:0] x_vec [NMAX];
    int    order_reg = 4;
    bit    sat_seen, pivot_seen;
    x_item_t expected_x[$];
    int    errors = 0;
    int    cycles = 0;
    int    tx_idle = 0, rx_idle = 0, rx_hold = 0;

    function automatic logic signed [31:0] clip_q(longint v);
        if (v > 64'sd2147483647) begin
            sat_seen = 1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            sat_seen = 1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic longint mul_q(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FRAC;
    endfunction

    function automatic logic signed [31:0] div_q(logic signed [31:0] num,
                                                 logic signed [31:0] den);
        if (den == 0) begin
            pivot_seen = 1;
            return 0;
        end
        return clip_q((longint'(num) <<< FRAC) / longint'(den));
    endfunction

    task automatic predict_solution(bit push);
        int n;
        longint s;
        x_item_t e;
        n = order_reg < 1 ? 1 : (order_reg > NMAX ? NMAX : order_reg);
        sat_seen = 0;
        pivot_seen = 0;
        for (int i = 0; i < n; i++) begin
            for (int j = i; j < n; j++) begin
                s = 0;
                for (int k = 0; k < i; k++)
                    s += mul_q(lu_cell[i*NMAX+k], lu_cell[k*NMAX+j]);
                lu_cell[i*NMAX+j] = clip_q(longint'(lu_cell[i*NMAX+j]) - s);
            end
            for (int j = i + 1; j < n; j++) begin
                s = 0;
                for (int k = 0; k < i; k++)
                    s += mul_q(lu_cell[j*NMAX+k], lu_cell[k*NMAX+i]);
                lu_cell[j*NMAX+i] = div_q(clip_q(longint'(lu_cell[j*NMAX+i]) - s),
                                          lu_cell[i*NMAX+i]);
            end
        end
        for (int i = 0; i < n; i++) begin
            s = 0;
            for (int j = 0; j < i; j++)
                s += mul_q(lu_cell[i*NMAX+j], x_vec[j]);
            x_vec[i] = clip_q(longint'(rhs_vec[i]) - s);
        end
        for (int i = n - 1; i >= 0; i--) begin
            s = 0;
            for (int j = i + 1; j < n; j++)
                s += mul_q(lu_cell[i*NMAX+j], x_vec[j]);
            x_vec[i] = div_q(clip_q(longint'(x_vec[i]) - s), lu_cell[i*NMAX+i]);
        end
        if (push) begin
            for (int i = n - 1; i >= 0; i--) begin
                e.idx = 3'(i);
                e.val = x_vec[i];
                e.sts = pivot_seen ? STS_PIVOT : (sat_seen ? STS_SAT : STS_OK);
                e.last = (i == 0);
                expected_x.push_back(e);
            end
        end
    endtask

    task automatic send_entry(logic [1:0] cmd, logic [2:0] row, logic [2:0] col,
                              logic [31:0] val, bit push);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = {2'b00, val, col, row};
        do @(posedge i_clk); while (!s_axis_tready);
        case (cmd)
            CMD_MAT:   lu_cell[row*NMAX+col] = val;
            CMD_RHS:   rhs_vec[row] = val;
            CMD_SOLVE: predict_solution(push);
            default: ;
        endcase
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_x.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_order(logic [3:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        order_reg = v;
    endtask

    task automatic load_and_solve(int n);
        int d;
        logic [31:0] v;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if ($urandom_range(15) == 0) v = $urandom;
                else if (i == j) begin
                    d = $urandom_range(12 << FRAC, 2 << FRAC);
                    v = $urandom_range(1) ? d : -d;
                end else if ($urandom_range(9) == 0) v = 0;
                else v = $urandom_range(2 << FRAC) - (1 << FRAC);
                send_entry(CMD_MAT, 3'(i), 3'(j), v, 1);
                if ($urandom_range(19) == 0)
                    send_entry(CMD_NONE, 3'($urandom), 3'($urandom), $urandom, 1);
            end
            v = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32 << FRAC) - (16 << FRAC);
            send_entry(CMD_RHS, 3'(i), 3'd0, v, 1);
        end
        if ($urandom_range(3) == 0)
            send_entry(CMD_MAT, 3'($urandom), 3'($urandom), $urandom, 1);
        send_entry(CMD_SOLVE, 3'($urandom), 3'($urandom), $urandom, 1);
        if ($urandom_range(4) == 0)
            send_entry(CMD_SOLVE, 3'd0, 3'd0, 32'd0, 1);
    endtask

    stim_row_t directed[] = '{
        '{CMD_MAT,   0, 0, 32'h0001_0000, 0, 0, 0},
        '{CMD_RHS,   0, 0, 32'h0005_0000, 0, 0, 0},
        '{CMD_SOLVE, 0, 0, 32'h0000_0000, 1, 32'h0005_0000, STS_OK},
        '{CMD_MAT,   0, 0, 32'h0000_0000, 0, 0, 0},
        '{CMD_SOLVE, 7, 7, 32'hFFFF_FFFF, 1, 32'h0000_0000, STS_PIVOT},
        '{CMD_MAT,   0, 0, 32'h0000_0001, 0, 0, 0},
        '{CMD_RHS,   0, 0, 32'h7FFF_FFFF, 0, 0, 0},
        '{CMD_SOLVE, 0, 0, 32'h0000_0000, 1, 32'h7FFF_FFFF, STS_SAT},
        '{CMD_MAT,   0, 0, 32'hFFFF_0000, 0, 0, 0},
        '{CMD_RHS,   0, 0, 32'h8000_0000, 0, 0, 0},
        '{CMD_SOLVE, 0, 0, 32'h0000_0000, 1, 32'h7FFF_FFFF, STS_SAT},
        '{CMD_MAT,   7, 7, 32'h8000_0000, 0, 0, 0},
        '{CMD_RHS,   7, 0, 32'h7FFF_FFFF, 0, 0, 0},
        '{CMD_NONE,  7, 7, 32'hFFFF_FFFF, 0, 0, 0},
        '{CMD_SOLVE, 0, 0, 32'h0000_0000, 0, 0, 0},
        '{CMD_MAT,   0, 0, 32'h0002_0000, 0, 0, 0},
        '{CMD_RHS,   0, 0, 32'hFFFD_0000, 0, 0, 0},
        '{CMD_SOLVE, 0, 0, 32'h0000_0000, 1, 32'hFFFE_8000, STS_OK}
    };

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_axis_tready = 1'b0;
                rx_hold--;
            end else begin
                m_axis_tready = ($urandom_range(99) >= rx_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        x_item_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_x.size() == 0) begin
                $display("%0t: unexpected transfer idx=%0d x=%h sts=%0d last=%b", $time,
                         m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                e = expected_x.pop_front();
                if (m_axis_tdata[2:0] !== e.idx || m_axis_tdata[34:3] !== e.val ||
                    m_axis_tuser !== e.sts || m_axis_tlast !== e.last ||
                    m_axis_tdata[39:35] !== 5'd0) begin
                    $display("%0t: expected idx=%0d x=%h sts=%0d last=%b, got idx=%0d x=%h sts=%0d last=%b",
                             $time, e.idx, e.val, e.sts, e.last, m_axis_tdata[2:0],
                             m_axis_tdata[34:3], m_axis_tuser, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        x_item_t e;
        int sizes[] = '{1, 2, 3, 2, 1, 3, 2, 2};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        set_order(1);
        tx_idle = 26;
        rx_idle = 70;
        foreach (directed[r]) begin
            send_entry(directed[r].cmd, directed[r].row, directed[r].col,
                       directed[r].val, !directed[r].known);
            if (directed[r].known) begin
                e.idx = 0;
                e.val = directed[r].xval;
                e.sts = directed[r].xsts;
                e.last = 1'b1;
                expected_x.push_back(e);
            end
        end
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle = phase == 0 ? 26 : (phase == 1 ? 70 : 0);
            rx_idle = phase == 0 ? 70 : (phase == 1 ? 26 : 0);
            for (int s = 0; s < 2; s++) begin
                if (s == 1 && phase == 0) set_order(0);
                else set_order(4'(sizes[$urandom_range(sizes.size() - 1)]));
                if (s == 1) rx_hold = 400;
                load_and_solve(order_reg < 1 ? 1 : order_reg);
            end
        end
        set_order(15);
        load_and_solve(NMAX);
        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_x.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- lu_linear_system_solver.f -----
rtl/luss_pkg.sv
rtl/luss_div.sv
rtl/luss_mac.sv
rtl/lu_linear_system_solver.sv
tb/testbench.sv
